### src/kmer_pkg.sv
// shared types and constants for the k-mer extractor
// no dependencies; compiled before the interfaces and the top level
package kmer_pkg;

    localparam int BYTES_PER_WORD_DEF = 8;
    localparam int POS_BITS_DEF       = 40;

    localparam int OUT_WORD_BITS = 64;
    localparam int OUT_POS_BITS  = 40;
    localparam int SEQ_BITS      = 32;
    localparam int RUN_BITS      = 6;
    localparam int CHAR_BITS     = 8;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KMER_LENGTH    = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_ENABLE = 8'd1;

    localparam logic [RUN_BITS-1:0] KMER_LENGTH_RESET = 6'd32;
    localparam logic [RUN_BITS-1:0] RUN_MAX           = 6'd63;

    localparam logic [CHAR_BITS-1:0] CHAR_GT = 8'h3E;
    localparam logic [CHAR_BITS-1:0] CHAR_LF = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_A  = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_C  = 8'h43;
    localparam logic [CHAR_BITS-1:0] CHAR_G  = 8'h47;
    localparam logic [CHAR_BITS-1:0] CHAR_T  = 8'h54;
    localparam logic [CHAR_BITS-1:0] CHAR_UA = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UZ = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_BITS-1:0] CHAR_LZ = 8'h7A;

    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [OUT_WORD_BITS-1:0] fwd_word;
        logic [OUT_WORD_BITS-1:0] rev_word;
        logic [SEQ_BITS-1:0]      seq_number;
        logic [OUT_POS_BITS-1:0]  fwd_pos;
        logic [OUT_POS_BITS-1:0]  rev_pos;
    } result_t;

endpackage

### src/kmer_if.sv
// valid/ready channels of the k-mer extractor: text bytes, result words, config writes
// depends on kmer_pkg
interface kmer_char_if;
    logic                           valid;
    logic                           ready;
    logic [kmer_pkg::CHAR_BITS-1:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink (input valid, input char_code, output ready);
endinterface

interface kmer_word_if;
    logic                               valid;
    logic                               ready;
    logic [kmer_pkg::OUT_WORD_BITS-1:0] fwd_word;
    logic [kmer_pkg::OUT_WORD_BITS-1:0] rev_word;
    logic [kmer_pkg::SEQ_BITS-1:0]      seq_number;
    logic [kmer_pkg::OUT_POS_BITS-1:0]  fwd_pos;
    logic [kmer_pkg::OUT_POS_BITS-1:0]  rev_pos;

    modport source (output valid, output fwd_word, output rev_word, output seq_number,
                    output fwd_pos, output rev_pos, input ready);
    modport sink (input valid, input fwd_word, input rev_word, input seq_number,
                  input fwd_pos, input rev_pos, output ready);
endinterface

interface kmer_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [kmer_pkg::CFG_IDX_BITS-1:0]  index;
    logic [kmer_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/dna_kmer_extractor_revcomp.sv
// k-mer extractor with reverse complement over a FASTA byte stream
// depends on kmer_pkg and the channel interfaces in kmer_if.sv
// result words are registered: the byte that completes a word loads it into the output buffer
// throughput: one byte per cycle while the second buffer slot is empty; the two-word
// output buffer keeps bytes flowing while the result side stalls until that slot fills
// reset: k = 32, reverse on, words and counters zero, first line skipped
module dna_kmer_extractor_revcomp #(
    parameter int BYTES_PER_WORD = kmer_pkg::BYTES_PER_WORD_DEF,
    parameter int POS_BITS       = kmer_pkg::POS_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    kmer_char_if.sink    text,
    kmer_word_if.source  kmer,
    kmer_cfg_if.sink     cfg
);

    localparam int WORD_BITS = 8 * BYTES_PER_WORD;

    logic [kmer_pkg::RUN_BITS-1:0] k_reg;
    logic                          rev_en_reg;

    logic [WORD_BITS-1:0]          fwd_reg, fwd_next;
    logic [WORD_BITS-1:0]          rev_reg, rev_next;
    logic [kmer_pkg::RUN_BITS-1:0] run_reg, run_next;
    logic [POS_BITS-1:0]           pos_reg, pos_next;
    logic [kmer_pkg::SEQ_BITS-1:0] seq_reg, seq_next;
    logic                          skip_reg, skip_next;

    kmer_pkg::result_t main_reg, main_next;
    kmer_pkg::result_t skid_reg, skid_next;
    logic              main_valid_reg, main_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    kmer_pkg::result_t new_result;
    logic              accept;
    logic              emit;
    logic              push;
    logic              pop;
    logic              is_letter;
    logic              good;
    logic [1:0]        code;
    logic [POS_BITS-1:0] fwd_diff;
    logic [POS_BITS-1:0] rev_diff;

    assign accept    = text.valid && text.ready;
    assign text.ready = !skid_valid_reg;
    assign cfg.ready = 1'b1;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= kmer_pkg::KMER_LENGTH_RESET;
            rev_en_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                kmer_pkg::CFG_KMER_LENGTH:    k_reg <= cfg.data[kmer_pkg::RUN_BITS-1:0];
                kmer_pkg::CFG_REVERSE_ENABLE: rev_en_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // byte decode
    always_comb
    begin
        is_letter = (text.char_code inside {[kmer_pkg::CHAR_UA:kmer_pkg::CHAR_UZ]})
                 || (text.char_code inside {[kmer_pkg::CHAR_LA:kmer_pkg::CHAR_LZ]});
        good = 1'b1;
        case (text.char_code)
            kmer_pkg::CHAR_A: code = kmer_pkg::BASE_A;
            kmer_pkg::CHAR_C: code = kmer_pkg::BASE_C;
            kmer_pkg::CHAR_G: code = kmer_pkg::BASE_G;
            kmer_pkg::CHAR_T: code = kmer_pkg::BASE_T;
            default:
            begin
                code = kmer_pkg::BASE_A;
                good = 1'b0;
            end
        endcase
    end

    // next sequence state
    always_comb
    begin
        fwd_next  = fwd_reg;
        rev_next  = rev_reg;
        run_next  = run_reg;
        pos_next  = pos_reg;
        seq_next  = seq_reg;
        skip_next = skip_reg;
        emit      = 1'b0;
        if (skip_reg)
        begin
            if (text.char_code == kmer_pkg::CHAR_LF)
                skip_next = 1'b0;
        end
        else if (!is_letter)
        begin
            if (text.char_code == kmer_pkg::CHAR_GT)
            begin
                if (!(&seq_reg))
                    seq_next = seq_reg + 1'b1;
                if (!(&pos_reg))
                    pos_next = pos_reg + 1'b1;
                run_next  = '0;
                skip_next = 1'b1;
            end
        end
        else
        begin
            fwd_next = {fwd_reg[WORD_BITS-3:0], code};
            rev_next = {(good ? ~code : 2'b00), rev_reg[WORD_BITS-1:2]};
            if (good)
            begin
                if (run_reg != kmer_pkg::RUN_MAX)
                    run_next = run_reg + 1'b1;
            end
            else
                run_next = '0;
            if (!(&pos_reg))
                pos_next = pos_reg + 1'b1;
            emit = (run_next >= k_reg);
        end
    end

    assign fwd_diff = pos_next - POS_BITS'(k_reg);
    assign rev_diff = pos_next - POS_BITS'(1);

    always_comb
    begin
        logic [63:0] fwd_ext;
        logic [63:0] rev_ext;
        fwd_ext = 64'(fwd_diff);
        rev_ext = 64'(rev_diff);
        new_result.fwd_word   = kmer_pkg::OUT_WORD_BITS'(fwd_next);
        new_result.rev_word   = rev_en_reg ? kmer_pkg::OUT_WORD_BITS'(rev_next) : '0;
        new_result.seq_number = seq_next;
        new_result.fwd_pos    = fwd_ext[kmer_pkg::OUT_POS_BITS-1:0];
        new_result.rev_pos    = rev_en_reg ? rev_ext[kmer_pkg::OUT_POS_BITS-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= '0;
            rev_reg  <= '0;
            run_reg  <= '0;
            pos_reg  <= '0;
            seq_reg  <= '0;
            skip_reg <= 1'b1;
        end
        else if (accept)
        begin
            fwd_reg  <= fwd_next;
            rev_reg  <= rev_next;
            run_reg  <= run_next;
            pos_reg  <= pos_next;
            seq_reg  <= seq_next;
            skip_reg <= skip_next;
        end
    end

    // two-word output buffer
    assign push = accept && emit;
    assign pop  = kmer.valid && kmer.ready;

    always_comb
    begin
        main_next       = main_reg;
        skid_next       = skid_reg;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = new_result;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign kmer.valid      = main_valid_reg;
    assign kmer.fwd_word   = main_reg.fwd_word;
    assign kmer.rev_word   = main_reg.rev_word;
    assign kmer.seq_number = main_reg.seq_number;
    assign kmer.fwd_pos    = main_reg.fwd_pos;
    assign kmer.rev_pos    = main_reg.rev_pos;

    // buffer order: second slot only fills behind the first
    assert property (@(posedge clk) disable iff (!rst_n) skid_valid_reg |-> main_valid_reg)
        else $error("skid word held without head word");

    // reverse off gives zero reverse fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (kmer.valid && !rev_en_reg) |-> (kmer.rev_word == '0 && kmer.rev_pos == '0))
        else $error("reverse fields not zero with reverse disabled");

    // position holds while a line is skipped
    assert property (@(posedge clk) disable iff (!rst_n) skip_reg |=> $stable(pos_reg))
        else $error("position moved inside a skipped line");

    // header mark starts a skip and clears the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !skip_reg && text.char_code == kmer_pkg::CHAR_GT)
        |=> (skip_reg && run_reg == '0))
        else $error("header mark did not start a skip");

endmodule

### verif/dna_kmer_extractor_revcomp_tb.sv
// testbench for dna_kmer_extractor_revcomp: FASTA text bytes in, 2-bit k-mer words out
// predicts every word with a behavioral model and checks it field by field
// depends on kmer_pkg, the channel interfaces in kmer_if.sv and the top level
module dna_kmer_extractor_revcomp_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_MAX     = 40;
    localparam int PHASE_LETTERS = 240;
    localparam int MIN_WORDS     = 40;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [kmer_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 8'd2;
    localparam logic [kmer_pkg::CFG_IDX_BITS-1:0] CFG_TOP_IDX    = 8'hFF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kmer_char_if text_ch();
    kmer_word_if word_ch();
    kmer_cfg_if  cfg_ch();

    dna_kmer_extractor_revcomp dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .kmer  (word_ch),
        .cfg   (cfg_ch)
    );

    logic [kmer_pkg::RUN_BITS-1:0]      kmer_len;
    logic                               rev_on;
    logic [kmer_pkg::OUT_WORD_BITS-1:0] fwd_bases;
    logic [kmer_pkg::OUT_WORD_BITS-1:0] rev_bases;
    logic [kmer_pkg::RUN_BITS-1:0]      good_run;
    logic [kmer_pkg::POS_BITS_DEF-1:0]  base_pos;
    logic [kmer_pkg::SEQ_BITS-1:0]      seq_idx;
    logic                               in_skip;

    kmer_pkg::result_t kmer_expected[$];
    int unsigned       bytes_sent;
    int unsigned       letters_seen;
    int unsigned       words_due;
    int unsigned       words_checked;
    int unsigned       settings_used;
    int unsigned       mismatches;
    bit                src_idle_on;
    bit                sink_idle_on;
    int unsigned       stall_left;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit is_letter(input logic [kmer_pkg::CHAR_BITS-1:0] c);
        return (c >= kmer_pkg::CHAR_UA && c <= kmer_pkg::CHAR_UZ)
            || (c >= kmer_pkg::CHAR_LA && c <= kmer_pkg::CHAR_LZ);
    endfunction

    function automatic void extract_kmer(input logic [kmer_pkg::CHAR_BITS-1:0] c);
        logic [1:0]        code;
        logic              good;
        kmer_pkg::result_t r;
        if (in_skip)
        begin
            if (c == kmer_pkg::CHAR_LF)
                in_skip = 1'b0;
            return;
        end
        if (!is_letter(c))
        begin
            if (c == kmer_pkg::CHAR_GT)
            begin
                if (seq_idx != '1)
                    seq_idx++;
                if (base_pos != '1)
                    base_pos++;
                good_run = '0;
                in_skip  = 1'b1;
            end
            return;
        end
        letters_seen++;
        good = 1'b1;
        case (c)
            kmer_pkg::CHAR_A: code = kmer_pkg::BASE_A;
            kmer_pkg::CHAR_C: code = kmer_pkg::BASE_C;
            kmer_pkg::CHAR_G: code = kmer_pkg::BASE_G;
            kmer_pkg::CHAR_T: code = kmer_pkg::BASE_T;
            default:
            begin
                code = kmer_pkg::BASE_A;
                good = 1'b0;
            end
        endcase
        fwd_bases = {fwd_bases[kmer_pkg::OUT_WORD_BITS-3:0], good ? code : 2'b00};
        rev_bases = {good ? ~code : 2'b00, rev_bases[kmer_pkg::OUT_WORD_BITS-1:2]};
        if (!good)
            good_run = '0;
        else if (good_run != kmer_pkg::RUN_MAX)
            good_run++;
        if (base_pos != '1)
            base_pos++;
        if (good_run >= kmer_len)
        begin
            r.fwd_word   = fwd_bases;
            r.seq_number = seq_idx;
            r.fwd_pos    = base_pos - kmer_len;
            r.rev_word   = rev_on ? rev_bases : '0;
            r.rev_pos    = rev_on ? base_pos - 40'd1 : '0;
            kmer_expected.push_back(r);
            words_due++;
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (!src_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic send_char(input logic [kmer_pkg::CHAR_BITS-1:0] c);
        int unsigned gap;
        text_ch.valid     <= 1'b1;
        text_ch.char_code <= c;
        do @(posedge clk); while (!text_ch.ready);
        extract_kmer(c);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        text_ch.valid <= 1'b0;
        while (kmer_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kmer_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [kmer_pkg::CFG_DATA_BITS-1:0] value,
                             input bit last);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        if (last)
            cfg_ch.valid <= 1'b0;
        if (idx == kmer_pkg::CFG_KMER_LENGTH)
            kmer_len = value[kmer_pkg::RUN_BITS-1:0];
        else if (idx == kmer_pkg::CFG_REVERSE_ENABLE)
            rev_on = value[0];
    endtask

    function automatic logic [kmer_pkg::CHAR_BITS-1:0] random_base();
        case ($urandom_range(0, 3))
            0: return kmer_pkg::CHAR_A;
            1: return kmer_pkg::CHAR_C;
            2: return kmer_pkg::CHAR_G;
            default: return kmer_pkg::CHAR_T;
        endcase
    endfunction

    function automatic logic [kmer_pkg::CHAR_BITS-1:0] messy_byte();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return random_base();
        if (r < 88)
            return kmer_pkg::CHAR_BITS'($urandom_range(kmer_pkg::CHAR_LA, kmer_pkg::CHAR_LZ));
        if (r < 94)
            return kmer_pkg::CHAR_BITS'($urandom_range(kmer_pkg::CHAR_UA, kmer_pkg::CHAR_UZ));
        return kmer_pkg::CHAR_BITS'($urandom_range(0, 255));
    endfunction

    task automatic send_header();
        logic [kmer_pkg::CHAR_BITS-1:0] b;
        send_char(kmer_pkg::CHAR_GT);
        repeat ($urandom_range(0, 10))
        begin
            b = kmer_pkg::CHAR_BITS'($urandom_range(0, 255));
            send_char(b == kmer_pkg::CHAR_LF ? kmer_pkg::CHAR_GT : b);
        end
        send_char(kmer_pkg::CHAR_LF);
    endtask

    task automatic send_record(input bit clean, input int unsigned len);
        int unsigned line_w;
        int unsigned col;
        line_w = $urandom_range(8, 70);
        col    = 0;
        for (int i = 0; i < len; i++)
        begin
            send_char(clean ? random_base() : messy_byte());
            col++;
            if (col == line_w)
            begin
                send_char(kmer_pkg::CHAR_LF);
                col = 0;
            end
        end
        send_char(kmer_pkg::CHAR_LF);
    endtask

    // first line is swallowed whole at reset settings, k = 32 so nothing comes out
    task automatic test_first_line_skip();
        settings_used++;
        send_char(kmer_pkg::CHAR_A);
        send_char(kmer_pkg::CHAR_GT);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(kmer_pkg::CHAR_G);
        send_char(kmer_pkg::CHAR_LF);
        send_char(kmer_pkg::CHAR_C);
    endtask

    task automatic test_base_codes();
        wait_idle();
        write_reg(kmer_pkg::CFG_KMER_LENGTH, 8'd2, 1'b0);
        write_reg(kmer_pkg::CFG_REVERSE_ENABLE, 8'd1, 1'b1);
        settings_used++;
        send_char(kmer_pkg::CHAR_A);
        send_char(kmer_pkg::CHAR_C);
        send_char(kmer_pkg::CHAR_G);
        send_char(kmer_pkg::CHAR_T);
        send_char(8'h61);
        send_char(8'h4E);
        send_char(8'h35);
        send_char(8'h80);
        send_char(kmer_pkg::CHAR_C);
        send_char(kmer_pkg::CHAR_A);
        send_char(kmer_pkg::CHAR_GT);
        send_char(8'h78);
        send_char(kmer_pkg::CHAR_LF);
        send_char(kmer_pkg::CHAR_G);
        send_char(kmer_pkg::CHAR_T);
    endtask

    // unused indexes are ignored, k comes from the low six bits only
    task automatic test_zero_k_no_reverse();
        wait_idle();
        write_reg(CFG_UNUSED_IDX, 8'hFF, 1'b0);
        write_reg(CFG_TOP_IDX, 8'h00, 1'b0);
        write_reg(kmer_pkg::CFG_KMER_LENGTH, 8'hC0, 1'b0);
        write_reg(kmer_pkg::CFG_REVERSE_ENABLE, 8'hFE, 1'b1);
        settings_used++;
        send_char(8'h7A);
        send_char(kmer_pkg::CHAR_A);
    endtask

    task automatic test_random_text(input logic [kmer_pkg::CFG_DATA_BITS-1:0] k_data,
                                    input logic [kmer_pkg::CFG_DATA_BITS-1:0] rev_data);
        int unsigned letters0;
        int unsigned words0;
        int unsigned len;
        wait_idle();
        write_reg(kmer_pkg::CFG_KMER_LENGTH, k_data, 1'b0);
        write_reg(kmer_pkg::CFG_REVERSE_ENABLE, rev_data, 1'b1);
        settings_used++;
        letters0 = letters_seen;
        words0   = words_due;
        while (letters_seen - letters0 < PHASE_LETTERS || words_due - words0 < MIN_WORDS)
        begin
            src_idle_on  = $urandom_range(0, 9) < 7;
            sink_idle_on = $urandom_range(0, 9) < 7;
            send_header();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 240)
                                              : $urandom_range(10, 90);
            send_record($urandom_range(0, 99) < 65, len);
        end
    endtask

    task automatic test_settings_sweep();
        test_random_text(8'd32, 8'd1);
        test_random_text(8'd1, 8'h00);
        test_random_text(8'hFF, 8'hFF);
        test_random_text(8'd145, 8'h02);
        test_random_text(kmer_pkg::CFG_DATA_BITS'($urandom),
                         kmer_pkg::CFG_DATA_BITS'($urandom));
        test_random_text(8'd64, 8'd1);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            word_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (!sink_idle_on || $urandom_range(0, 99) < 70)
            word_ch.ready <= 1'b1;
        else
        begin
            word_ch.ready <= 1'b0;
            stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 30);
        end
    end

    always @(posedge clk)
    begin : check_words
        kmer_pkg::result_t want;
        if (rst_n && word_ch.valid && word_ch.ready)
        begin
            if (kmer_expected.size() == 0)
                report_mismatch("word with none pending", word_ch.fwd_word, '0);
            else
            begin
                want = kmer_expected.pop_front();
                words_checked++;
                if (word_ch.fwd_word !== want.fwd_word)
                    report_mismatch("fwd_word", word_ch.fwd_word, want.fwd_word);
                if (word_ch.rev_word !== want.rev_word)
                    report_mismatch("rev_word", word_ch.rev_word, want.rev_word);
                if (word_ch.seq_number !== want.seq_number)
                    report_mismatch("seq_number", word_ch.seq_number, want.seq_number);
                if (word_ch.fwd_pos !== want.fwd_pos)
                    report_mismatch("fwd_pos", word_ch.fwd_pos, want.fwd_pos);
                if (word_ch.rev_pos !== want.rev_pos)
                    report_mismatch("rev_pos", word_ch.rev_pos, want.rev_pos);
            end
        end
    end

    initial
    begin
        #15_000_000;
        $display("timeout with %0d words outstanding", kmer_expected.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        text_ch.valid     = 1'b0;
        text_ch.char_code = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        word_ch.ready     = 1'b0;
        kmer_len          = kmer_pkg::KMER_LENGTH_RESET;
        rev_on            = 1'b1;
        fwd_bases         = '0;
        rev_bases         = '0;
        good_run          = '0;
        base_pos          = '0;
        seq_idx           = '0;
        in_skip           = 1'b1;
        bytes_sent        = 0;
        letters_seen      = 0;
        words_due         = 0;
        words_checked     = 0;
        settings_used     = 0;
        mismatches        = 0;
        stall_left        = 0;
        src_idle_on       = 1'b1;
        sink_idle_on      = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_first_line_skip();
        test_base_codes();
        test_zero_k_no_reverse();
        test_settings_sweep();
        wait_idle();
        repeat (10) @(posedge clk);
        $display("%0d text bytes (%0d letters), %0d words checked over %0d register settings",
                 bytes_sent, letters_seen, words_checked, settings_used);
        $display("k from 0 to 63, reverse on and off, headers, bad bases and noise bytes");
        if (mismatches == 0 && kmer_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
